FILE: rtl/pgt_pkg.sv
package pgt_pkg;

   localparam int unsigned ROW_IN_W    = 6;
   localparam int unsigned COL_IN_W    = 6;
   localparam int unsigned COLOR_IN_W  = 4;
   localparam int unsigned CFG_W       = 5;
   localparam int unsigned LIKE_W      = 14;
   localparam int unsigned HORIZ_W     = 13;

   localparam logic [CFG_W-1:0] COLOR_COUNT_RESET = 5'd2;

   localparam logic [1:0] NB_DOWN  = 2'd0;
   localparam logic [1:0] NB_UP    = 2'd1;
   localparam logic [1:0] NB_RIGHT = 2'd2;

   typedef enum logic [2:0] {
      ADDR_IN,
      ADDR_DOWN,
      ADDR_UP,
      ADDR_RIGHT,
      ADDR_LEFT,
      ADDR_CELL,
      ADDR_CLEAR
   } addr_sel_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_DOWN,
      ST_RD_UP,
      ST_RD_RIGHT,
      ST_RD_LEFT,
      ST_WRITE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic         accept;
      addr_sel_type addr_sel;
      logic         mem_we;
      logic         cap_old;
      logic         cap_nb;
      logic [1:0]   nb_idx;
      logic         commit;
      logic         report;
      logic         clear_step;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic out_free;
      logic clear_last;
   } status_type;

endpackage

FILE: rtl/pgt_req_if.sv
interface pgt_req_if;
   import pgt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ROW_IN_W-1:0]   row;
   logic [COL_IN_W-1:0]   col;
   logic [COLOR_IN_W-1:0] new_color;

   modport source (output valid, row, col, new_color, input ready);
   modport sink (input valid, row, col, new_color, output ready);

endinterface

FILE: rtl/pgt_rsp_if.sv
interface pgt_rsp_if;
   import pgt_pkg::*;

   logic               valid;
   logic               ready;
   logic [LIKE_W-1:0]  like_pairs;
   logic [HORIZ_W-1:0] horizontal_like_pairs;
   logic               rejected;

   modport source (output valid, like_pairs, horizontal_like_pairs, rejected, input ready);
   modport sink (input valid, like_pairs, horizontal_like_pairs, rejected, output ready);

endinterface

FILE: rtl/pgt_datapath.sv
module pgt_datapath #(
   parameter int unsigned ROWS       = 64,
   parameter int unsigned COLS       = 64,
   parameter int unsigned COLOR_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pgt_pkg::cmd_type              cmd,
   output pgt_pkg::status_type           status,
   input  logic [pgt_pkg::ROW_IN_W-1:0]  in_row,
   input  logic [pgt_pkg::COL_IN_W-1:0]  in_col,
   input  logic [pgt_pkg::COLOR_IN_W-1:0] in_color,
   input  logic [pgt_pkg::CFG_W-1:0]     color_count,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [pgt_pkg::LIKE_W-1:0]    out_like,
   output logic [pgt_pkg::HORIZ_W-1:0]   out_horiz,
   output logic                          out_rejected
);
   import pgt_pkg::*;

   localparam int unsigned Cells    = ROWS * COLS;
   localparam int unsigned RW       = $clog2(ROWS);
   localparam int unsigned CW       = $clog2(COLS);
   localparam int unsigned AW       = $clog2(Cells);
   localparam int unsigned ColorMax = (1 << COLOR_BITS) - 1;
   localparam logic [LIKE_W-1:0]  LikeReset  = LIKE_W'(2 * Cells);
   localparam logic [HORIZ_W-1:0] HorizReset = HORIZ_W'(Cells);

   // wrap tables for the narrow index fields
   logic [RW-1:0] row_mod [2**ROW_IN_W];
   logic [CW-1:0] col_mod [2**COL_IN_W];

   for (genvar gi = 0; gi < 2**ROW_IN_W; gi++) begin : g_row_mod
      assign row_mod[gi] = RW'(gi % ROWS);
   end
   for (genvar gj = 0; gj < 2**COL_IN_W; gj++) begin : g_col_mod
      assign col_mod[gj] = CW'(gj % COLS);
   end

   logic [COLOR_BITS-1:0] grid_mem [Cells];

   logic [RW-1:0]         row_ff, row_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic [COLOR_BITS-1:0] old_ff;
   logic [COLOR_BITS-1:0] nb_ff [3];
   logic [COLOR_BITS-1:0] rd_data_ff;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [LIKE_W-1:0]     pair_ff, pair_in;
   logic [HORIZ_W-1:0]    horiz_ff, horiz_in;
   logic                  out_valid_ff, out_valid_in;
   logic [LIKE_W-1:0]     out_like_ff;
   logic [HORIZ_W-1:0]    out_horiz_ff;
   logic                  out_rej_ff;

   logic [RW-1:0]         row_dn, row_up, a_row;
   logic [CW-1:0]         col_rt, col_lt, a_col;
   logic [AW-1:0]         addr;
   logic [COLOR_BITS-1:0] wr_data;
   logic [COLOR_BITS-1:0] left_color;
   logic [2:0]            a_old, a_new;
   logic [1:0]            h_old, h_new;

   // neighbour indices with toroidal wrap
   always_comb begin
      row_dn = (row_ff == RW'(ROWS - 1)) ? '0 : row_ff + RW'(1);
      row_up = (row_ff == '0) ? RW'(ROWS - 1) : row_ff - RW'(1);
      col_rt = (col_ff == CW'(COLS - 1)) ? '0 : col_ff + CW'(1);
      col_lt = (col_ff == '0) ? CW'(COLS - 1) : col_ff - CW'(1);
   end

   always_comb begin
      a_row = row_ff;
      a_col = col_ff;
      unique case (cmd.addr_sel)
         ADDR_IN: begin
            a_row = row_mod[in_row];
            a_col = col_mod[in_col];
         end
         ADDR_DOWN:  a_row = row_dn;
         ADDR_UP:    a_row = row_up;
         ADDR_RIGHT: a_col = col_rt;
         ADDR_LEFT:  a_col = col_lt;
         ADDR_CELL, ADDR_CLEAR: begin
            a_row = row_ff;
            a_col = col_ff;
         end
         default: begin
            a_row = row_ff;
            a_col = col_ff;
         end
      endcase
      if (cmd.addr_sel == ADDR_CLEAR) begin
         addr    = clr_ff;
         wr_data = '0;
      end else begin
         addr    = AW'(a_row) * AW'(COLS) + AW'(a_col);
         wr_data = color_ff;
      end
   end

   // single-port grid memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         grid_mem[addr] <= wr_data;
      end else begin
         rd_data_ff <= grid_mem[addr];
      end
   end

   // match counts against the four neighbours
   always_comb begin
      left_color = rd_data_ff;
      a_old = 3'(nb_ff[NB_DOWN] == old_ff) + 3'(nb_ff[NB_UP] == old_ff)
            + 3'(nb_ff[NB_RIGHT] == old_ff) + 3'(left_color == old_ff);
      h_old = 2'(nb_ff[NB_RIGHT] == old_ff) + 2'(left_color == old_ff);
      a_new = 3'(nb_ff[NB_DOWN] == color_ff) + 3'(nb_ff[NB_UP] == color_ff)
            + 3'(nb_ff[NB_RIGHT] == color_ff) + 3'(left_color == color_ff);
      h_new = 2'(nb_ff[NB_RIGHT] == color_ff) + 2'(left_color == color_ff);
   end

   always_comb begin
      row_in   = cmd.accept ? row_mod[in_row] : row_ff;
      col_in   = cmd.accept ? col_mod[in_col] : col_ff;
      color_in = cmd.accept ? COLOR_BITS'(in_color) : color_ff;
      clr_in   = cmd.clear_step ? clr_ff + AW'(1) : clr_ff;
      pair_in  = pair_ff;
      horiz_in = horiz_ff;
      if (cmd.commit) begin
         pair_in  = pair_ff + LIKE_W'(a_new) - LIKE_W'(a_old);
         horiz_in = horiz_ff + HORIZ_W'(h_new) - HORIZ_W'(h_old);
      end
      out_valid_in = out_valid_ff && !out_ready;
      if (cmd.commit || cmd.report) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         pair_ff      <= LikeReset;
         horiz_ff     <= HorizReset;
         out_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         pair_ff      <= pair_in;
         horiz_ff     <= horiz_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      color_ff <= color_in;
      if (cmd.cap_old) begin
         old_ff <= rd_data_ff;
      end
      if (cmd.cap_nb) begin
         nb_ff[cmd.nb_idx] <= rd_data_ff;
      end
      if (cmd.commit || cmd.report) begin
         out_like_ff  <= pair_in;
         out_horiz_ff <= horiz_in;
         out_rej_ff   <= cmd.report;
      end
   end

   always_comb begin
      status.reject     = ({1'b0, in_color} >= color_count) || (32'(in_color) > ColorMax);
      status.out_free   = !out_valid_ff || out_ready;
      status.clear_last = (clr_ff == AW'(Cells - 1));
   end

   assign out_valid    = out_valid_ff;
   assign out_like     = out_like_ff;
   assign out_horiz    = out_horiz_ff;
   assign out_rejected = out_rej_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.report) |-> (!out_valid_ff || out_ready))
      else $error("result loaded over an untaken item");

   a_report_keeps: assert property (@(posedge clock) disable iff (reset)
      cmd.report |=> (pair_ff == $past(pair_ff)) && (horiz_ff == $past(horiz_ff)))
      else $error("rejected item changed the counts");

   a_same_color: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (old_ff == color_ff)) |=>
         (pair_ff == $past(pair_ff)) && (horiz_ff == $past(horiz_ff)))
      else $error("rewrite of the same colour changed the counts");

endmodule

FILE: rtl/pgt_ctrl.sv
module pgt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pgt_pkg::status_type status,
   output pgt_pkg::cmd_type    cmd
);
   import pgt_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.reject ? ST_REPORT : ST_RD_DOWN;
            end
         end
         ST_RD_DOWN:  state_in = ST_RD_UP;
         ST_RD_UP:    state_in = ST_RD_RIGHT;
         ST_RD_RIGHT: state_in = ST_RD_LEFT;
         ST_RD_LEFT:  state_in = ST_WRITE;
         ST_WRITE:    if (status.out_free) state_in = ST_IDLE;
         ST_REPORT:   if (status.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.addr_sel   = ADDR_CELL;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.addr_sel   = ADDR_CLEAR;
            cmd.mem_we     = 1'b1;
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.accept   = req_valid;
            cmd.addr_sel = ADDR_IN;
         end
         ST_RD_DOWN: begin
            cmd.addr_sel = ADDR_DOWN;
            cmd.cap_old  = 1'b1;
         end
         ST_RD_UP: begin
            cmd.addr_sel = ADDR_UP;
            cmd.cap_nb   = 1'b1;
            cmd.nb_idx   = NB_DOWN;
         end
         ST_RD_RIGHT: begin
            cmd.addr_sel = ADDR_RIGHT;
            cmd.cap_nb   = 1'b1;
            cmd.nb_idx   = NB_UP;
         end
         ST_RD_LEFT: begin
            cmd.addr_sel = ADDR_LEFT;
            cmd.cap_nb   = 1'b1;
            cmd.nb_idx   = NB_RIGHT;
         end
         ST_WRITE: begin
            cmd.addr_sel = ADDR_CELL;
            cmd.mem_we   = 1'b1;
            cmd.commit   = status.out_free;
         end
         ST_REPORT: begin
            cmd.report = status.out_free;
         end
         default: begin
            cmd.addr_sel = ADDR_CELL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_path: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_RD_DOWN) || (state_ff == ST_REPORT))
      else $error("accepted item took no update path");

endmodule

FILE: rtl/potts_grid_energy_tracker_core.sv
// Potts grid energy tracker: holds a ROWS x COLS toroidal grid of colours and the counts of
// like-coloured neighbour pairs (all, and left-right only), each pair counted once. Every
// accepted item writes one cell and returns one result with both counts; a colour not below
// the configured colour count is refused with rejected set and nothing changed. An accepted
// write reads the cell and its four neighbours from the single-port grid memory in turn,
// then writes the cell and loads its result once the output register is free; a refused item
// also waits for it. After reset the grid is cleared to colour zero, one cell a cycle, before
// the first item is taken. The colour count register may be written at any time.
module potts_grid_energy_tracker_core #(
   parameter int unsigned ROWS       = 64,
   parameter int unsigned COLS       = 64,
   parameter int unsigned COLOR_BITS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   pgt_req_if.sink                    req_item,
   pgt_rsp_if.source                  rsp_item,
   input  logic                       csr_wr_en,
   input  logic [pgt_pkg::CFG_W-1:0]  csr_wr_data
);
   import pgt_pkg::*;

   logic [CFG_W-1:0] color_count_ff, color_count_in;
   cmd_type          cmd;
   status_type       status;

   always_comb begin
      color_count_in = csr_wr_en ? csr_wr_data : color_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_count_ff <= COLOR_COUNT_RESET;
      end else begin
         color_count_ff <= color_count_in;
      end
   end

   pgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_item.valid),
      .req_ready (req_item.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pgt_datapath #(
      .ROWS       (ROWS),
      .COLS       (COLS),
      .COLOR_BITS (COLOR_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_row       (req_item.row),
      .in_col       (req_item.col),
      .in_color     (req_item.new_color),
      .color_count  (color_count_ff),
      .out_valid    (rsp_item.valid),
      .out_ready    (rsp_item.ready),
      .out_like     (rsp_item.like_pairs),
      .out_horiz    (rsp_item.horizontal_like_pairs),
      .out_rejected (rsp_item.rejected)
   );

endmodule

FILE: verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pgt_pkg::*;

   localparam int GRID_ROWS   = 64;
   localparam int GRID_COLS   = 64;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [LIKE_W-1:0]  like_pairs;
      logic [HORIZ_W-1:0] horiz_pairs;
      logic               rejected;
   } pair_report_t;

   class like_pair_ledger;
      logic [COLOR_IN_W-1:0] colour_grid [GRID_ROWS][GRID_COLS];
      int unsigned           like_total;
      int unsigned           horiz_total;
      logic [CFG_W-1:0]      colour_limit;
      pair_report_t          pending_reports [$];
      int unsigned           mismatches;

      function new();
         foreach (colour_grid[r, c]) colour_grid[r][c] = '0;
         like_total   = 2 * GRID_ROWS * GRID_COLS;
         horiz_total  = GRID_ROWS * GRID_COLS;
         colour_limit = COLOR_COUNT_RESET;
         mismatches   = 0;
      endfunction

      function void neighbour_matches(input int r, input int c,
                                      input logic [COLOR_IN_W-1:0] v,
                                      output int unsigned all_m,
                                      output int unsigned horiz_m);
         int down_r;
         int up_r;
         int right_c;
         int left_c;
         down_r  = (r + 1) % GRID_ROWS;
         up_r    = (r + GRID_ROWS - 1) % GRID_ROWS;
         right_c = (c + 1) % GRID_COLS;
         left_c  = (c + GRID_COLS - 1) % GRID_COLS;
         all_m   = 0;
         horiz_m = 0;
         if (colour_grid[down_r][c] == v) all_m++;
         if (colour_grid[up_r][c] == v) all_m++;
         if (colour_grid[r][right_c] == v) begin
            all_m++;
            horiz_m++;
         end
         if (colour_grid[r][left_c] == v) begin
            all_m++;
            horiz_m++;
         end
      endfunction

      function void note_write(input logic [ROW_IN_W-1:0] row,
                               input logic [COL_IN_W-1:0] col,
                               input logic [COLOR_IN_W-1:0] colour);
         int           r;
         int           c;
         int unsigned  all_m;
         int unsigned  horiz_m;
         pair_report_t rep;
         r = int'(row) % GRID_ROWS;
         c = int'(col) % GRID_COLS;
         rep.rejected = (int'(colour) >= int'(colour_limit));
         if (!rep.rejected) begin
            neighbour_matches(r, c, colour_grid[r][c], all_m, horiz_m);
            like_total  -= all_m;
            horiz_total -= horiz_m;
            colour_grid[r][c] = colour;
            neighbour_matches(r, c, colour, all_m, horiz_m);
            like_total  += all_m;
            horiz_total += horiz_m;
         end
         rep.like_pairs  = LIKE_W'(like_total);
         rep.horiz_pairs = HORIZ_W'(horiz_total);
         pending_reports.push_back(rep);
      endfunction

      function void check_report(input pair_report_t got);
         pair_report_t want;
         if (pending_reports.size() == 0) begin
            $display("%0t: result with nothing expected, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         if (got.like_pairs !== want.like_pairs) begin
            $display("%0t: like_pairs expected %0d actual %0d",
                     $time, want.like_pairs, got.like_pairs);
            mismatches++;
         end
         if (got.horiz_pairs !== want.horiz_pairs) begin
            $display("%0t: horizontal_like_pairs expected %0d actual %0d",
                     $time, want.horiz_pairs, got.horiz_pairs);
            mismatches++;
         end
         if (got.rejected !== want.rejected) begin
            $display("%0t: rejected expected %0b actual %0b",
                     $time, want.rejected, got.rejected);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   pgt_req_if req_ch ();
   pgt_rsp_if rsp_ch ();

   potts_grid_energy_tracker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_ch),
      .rsp_item    (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   like_pair_ledger ledger;

   logic [15:0]         rx_pattern = 16'hFFFF;
   logic [3:0]          rx_phase = '0;
   int unsigned         cycle_count = 0;
   int                  burst_left = 4;
   int                  burst_span = 8;
   bit                  tx_active = 1'b0;
   logic [ROW_IN_W-1:0] win_row = '0;
   logic [COL_IN_W-1:0] win_col = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         ledger.check_report({rsp_ch.like_pairs, rsp_ch.horizontal_like_pairs,
                              rsp_ch.rejected});
      rsp_ch.ready <= rx_pattern[rx_phase];
      rx_phase     <= rx_phase + 4'd1;
   end

   task automatic push_item(input logic [ROW_IN_W-1:0] r, input logic [COL_IN_W-1:0] c,
                            input logic [COLOR_IN_W-1:0] k);
      req_ch.valid     <= 1'b1;
      req_ch.row       <= r;
      req_ch.col       <= c;
      req_ch.new_color <= k;
      tx_active = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ledger.note_write(r, c, k);
      burst_left--;
      if (burst_left <= 0) begin
         req_ch.valid <= 1'b0;
         tx_active = 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, burst_span);
      end
   endtask

   task automatic random_item();
      logic [ROW_IN_W-1:0]   r;
      logic [COL_IN_W-1:0]   c;
      logic [COLOR_IN_W-1:0] k;
      int                    lim;
      lim = int'(ledger.colour_limit);
      if (lim > 16) lim = 16;
      // mostly a small window so that writes meet their neighbours
      if ($urandom_range(0, 99) < 65) begin
         r = win_row + ROW_IN_W'($urandom_range(0, 3));
         c = win_col + COL_IN_W'($urandom_range(0, 3));
      end else begin
         r = ROW_IN_W'($urandom);
         c = COL_IN_W'($urandom);
      end
      if (lim > 0 && $urandom_range(0, 99) < 85)
         k = COLOR_IN_W'($urandom_range(0, lim - 1));
      else
         k = COLOR_IN_W'($urandom);
      push_item(r, c, k);
   endtask

   task automatic settle();
      if (tx_active) begin
         req_ch.valid <= 1'b0;
         tx_active = 1'b0;
      end
      while (ledger.pending_reports.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic new_phase(input logic [CFG_W-1:0] limit);
      settle();
      rx_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      burst_span = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, burst_span);
      if ($urandom_range(0, 1) == 0) begin
         win_row = 6'd62;
         win_col = 6'd62;
      end else begin
         win_row = ROW_IN_W'($urandom);
         win_col = COL_IN_W'($urandom);
      end
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.colour_limit = limit;
   endtask

   initial begin
      logic [CFG_W-1:0] limits [9];
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.row       = '0;
      req_ch.col       = '0;
      req_ch.new_color = '0;
      rsp_ch.ready     = 1'b0;
      ledger = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset colour count, wrap-around neighbours, rewrites and refusals
      push_item(6'd0, 6'd0, 4'd1);
      push_item(6'd0, 6'd1, 4'd1);
      push_item(6'd63, 6'd0, 4'd1);
      push_item(6'd0, 6'd63, 4'd1);
      push_item(6'd1, 6'd0, 4'd1);
      push_item(6'd0, 6'd0, 4'd1);
      push_item(6'd63, 6'd63, 4'd0);
      push_item(6'd0, 6'd0, 4'd0);
      push_item(6'd31, 6'd31, 4'd2);
      push_item(6'd63, 6'd63, 4'd15);

      new_phase(5'd16);
      push_item(6'd63, 6'd63, 4'd15);
      push_item(6'd63, 6'd0, 4'd15);
      push_item(6'd62, 6'd63, 4'd15);
      push_item(6'd0, 6'd63, 4'd15);
      push_item(6'd42, 6'd21, 4'd10);
      push_item(6'd42, 6'd21, 4'd10);
      push_item(6'd5, 6'd5, 4'd0);

      // colour count of zero refuses everything
      new_phase(5'd0);
      push_item(6'd0, 6'd0, 4'd0);
      push_item(6'd10, 6'd10, 4'd1);

      new_phase(5'd1);
      push_item(6'd0, 6'd1, 4'd0);
      push_item(6'd7, 6'd7, 4'd1);
      push_item(6'd63, 6'd62, 4'd0);

      new_phase(5'd31);
      push_item(6'd20, 6'd20, 4'd15);
      push_item(6'd20, 6'd21, 4'd15);
      push_item(6'd21, 6'd20, 4'd8);

      limits = '{5'd2, 5'd16, 5'd31, 5'd0, 5'd1, 5'd3, 5'd3, 5'd3, 5'd3};
      for (int i = 5; i < 9; i++) limits[i] = CFG_W'($urandom_range(2, 16));
      foreach (limits[i]) begin
         new_phase(limits[i]);
         repeat ((limits[i] == 0) ? 15 : 50) random_item();
      end

      settle();
      repeat (12) @(posedge clock);
      if (ledger.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
